>>> rtl/mdsu_pkg.sv
// Shared types and constants for the multiply, divide and shift unit.
package mdsu_pkg;

  // Operation codes carried by the kind field.
  typedef enum logic [2:0] {
    KindMulDiv    = 3'd0,
    KindMulDivShr = 3'd1,
    KindMulShlDiv = 3'd2,
    KindSmulShr   = 3'd3,
    KindUmulShr   = 3'd4
  } kind_e;

  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned ShiftW   = 6;
  localparam int unsigned KindW    = 3;
  localparam int unsigned DivSteps = ProdW;
  // Four front stages, one stage per quotient bit and one output stage.
  localparam int unsigned Latency  = 4 + DivSteps + 1;

  localparam logic [DataW-1:0] Uint32Max = {DataW{1'b1}};

  // Control that travels with each beat through the divider.
  typedef struct packed {
    logic              valid;
    logic [KindW-1:0]  kind;
    logic [ShiftW-1:0] shift;
    logic              div_zero;
    logic [DataW-1:0]  bypass;
  } ctl_t;

endpackage

>>> rtl/mdsu_div_stage.sv
// One registered restoring-division step producing one quotient bit.
module mdsu_div_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mdsu_pkg::ctl_t             ctl_i,
  input  logic [mdsu_pkg::DataW-1:0] den_i,
  input  logic [mdsu_pkg::DataW-1:0] rem_i,
  input  logic [mdsu_pkg::ProdW-1:0] num_i,
  output mdsu_pkg::ctl_t             ctl_o,
  output logic [mdsu_pkg::DataW-1:0] den_o,
  output logic [mdsu_pkg::DataW-1:0] rem_o,
  output logic [mdsu_pkg::ProdW-1:0] num_o
);

  logic [mdsu_pkg::DataW:0]   trial;
  logic                       fits;
  logic [mdsu_pkg::DataW-1:0] rem_d;
  logic [mdsu_pkg::ProdW-1:0] num_d;
  mdsu_pkg::ctl_t             ctl_q;
  logic [mdsu_pkg::DataW-1:0] den_q, rem_q;
  logic [mdsu_pkg::ProdW-1:0] num_q;

  // Bring down the next numerator bit and try the subtraction.
  always_comb begin
    trial = {rem_i, num_i[mdsu_pkg::ProdW-1]};
    fits  = (trial >= {1'b0, den_i});
    rem_d = fits ? trial[mdsu_pkg::DataW-1:0] - den_i : trial[mdsu_pkg::DataW-1:0];
    num_d = {num_i[mdsu_pkg::ProdW-2:0], fits};
  end

  // The control word, valid bit included, is reset; the datapath is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_i;
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign ctl_o = ctl_q;
  assign den_o = den_q;
  assign rem_o = rem_q;
  assign num_o = num_q;

endmodule

>>> rtl/multiply_divide_shift_unit.sv
// Top level of the pipelined multiply, divide and shift unit.
// Pipeline: 69 register stages (four front stages for multiply, sign correction and shift,
// 64 one-bit divider stages, one output stage).
// Throughput: one beat per cycle; busy_o is always low and nothing stalls.
// Reset: rst_ni clears every pipeline valid bit asynchronously; beats in flight are dropped.
module multiply_divide_shift_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [mdsu_pkg::KindW-1:0]  kind_i,
  input  logic [mdsu_pkg::DataW-1:0]  multiplicand_i,
  input  logic [mdsu_pkg::DataW-1:0]  multiplier_i,
  input  logic [mdsu_pkg::DataW-1:0]  divisor_i,
  input  logic [mdsu_pkg::ShiftW-1:0] shift_i,
  output logic                        valid_o,
  output logic [mdsu_pkg::DataW-1:0]  result_o
);

  localparam int unsigned DW = mdsu_pkg::DataW;
  localparam int unsigned PW = mdsu_pkg::ProdW;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Stage 1: two 16 by 32 partial products.
  logic                        v1_q;
  logic [mdsu_pkg::KindW-1:0]  kind1_q;
  logic [mdsu_pkg::ShiftW-1:0] sh1_q;
  logic [DW-1:0]               den1_q, mpl1_q;
  logic                        sign1_q;
  logic [47:0]                 pl1_q, ph1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    kind1_q <= kind_i;
    sh1_q   <= shift_i;
    den1_q  <= divisor_i;
    mpl1_q  <= multiplier_i;
    sign1_q <= multiplicand_i[DW-1];
    pl1_q   <= multiplicand_i[15:0] * multiplier_i;
    ph1_q   <= multiplicand_i[31:16] * multiplier_i;
  end

  // Stage 2: sum the partial products into the unsigned 64-bit product.
  logic                        v2_q;
  logic [mdsu_pkg::KindW-1:0]  kind2_q;
  logic [mdsu_pkg::ShiftW-1:0] sh2_q;
  logic [DW-1:0]               den2_q, mpl2_q;
  logic                        sign2_q;
  logic [PW-1:0]               prod2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind2_q <= kind1_q;
    sh2_q   <= sh1_q;
    den2_q  <= den1_q;
    mpl2_q  <= mpl1_q;
    sign2_q <= sign1_q;
    prod2_q <= {16'b0, pl1_q} + {ph1_q, 16'b0};
  end

  // Stage 3: a negative signed multiplicand subtracts the multiplier times 2^32.
  logic                        v3_q;
  logic [mdsu_pkg::KindW-1:0]  kind3_q;
  logic [mdsu_pkg::ShiftW-1:0] sh3_q;
  logic [DW-1:0]               den3_q;
  logic [PW-1:0]               prod3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind3_q <= kind2_q;
    sh3_q   <= sh2_q;
    den3_q  <= den2_q;
    if (kind2_q == mdsu_pkg::KindSmulShr && sign2_q) begin
      prod3_q <= prod2_q - {mpl2_q, 32'b0};
    end else begin
      prod3_q <= prod2_q;
    end
  end

  // Stage 4: left shift for the shift-then-divide kind, right shift for the multiply-only kinds.
  mdsu_pkg::ctl_t ctl4_d, ctl4_q;
  logic [PW-1:0]  num4_d, num4_q, shr4;
  logic [DW-1:0]  den4_q;

  always_comb begin
    shr4            = prod3_q >> sh3_q;
    ctl4_d.valid    = v3_q;
    ctl4_d.kind     = kind3_q;
    ctl4_d.shift    = sh3_q;
    ctl4_d.div_zero = (den3_q == '0);
    if (kind3_q == mdsu_pkg::KindSmulShr || kind3_q == mdsu_pkg::KindUmulShr) begin
      ctl4_d.bypass = shr4[DW-1:0];
    end else begin
      ctl4_d.bypass = '0;
    end
    num4_d = (kind3_q == mdsu_pkg::KindMulShlDiv) ? (prod3_q << sh3_q) : prod3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else begin
      ctl4_q <= ctl4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num4_q <= num4_d;
    den4_q <= den3_q;
  end

  // Divider chain: one quotient bit per stage, most significant first.
  mdsu_pkg::ctl_t ctl_s [0:mdsu_pkg::DivSteps];
  logic [DW-1:0]  den_s [0:mdsu_pkg::DivSteps];
  logic [DW-1:0]  rem_s [0:mdsu_pkg::DivSteps];
  logic [PW-1:0]  num_s [0:mdsu_pkg::DivSteps];

  assign ctl_s[0] = ctl4_q;
  assign den_s[0] = den4_q;
  assign rem_s[0] = '0;
  assign num_s[0] = num4_q;

  for (genvar g = 0; g < mdsu_pkg::DivSteps; g++) begin : g_div
    mdsu_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[g]),
      .den_i  (den_s[g]),
      .rem_i  (rem_s[g]),
      .num_i  (num_s[g]),
      .ctl_o  (ctl_s[g+1]),
      .den_o  (den_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .num_o  (num_s[g+1])
    );
  end

  // Output stage: select the result for the kind.
  mdsu_pkg::ctl_t ctl_f;
  logic [PW-1:0]  quo_f, quo_shr;
  logic [DW-1:0]  res_d, res_q;
  logic           valid_q;

  always_comb begin
    ctl_f   = ctl_s[mdsu_pkg::DivSteps];
    quo_f   = num_s[mdsu_pkg::DivSteps];
    quo_shr = quo_f >> ctl_f.shift;
    case (ctl_f.kind)
      mdsu_pkg::KindMulDiv,
      mdsu_pkg::KindMulShlDiv: res_d = ctl_f.div_zero ? mdsu_pkg::Uint32Max : quo_f[DW-1:0];
      mdsu_pkg::KindMulDivShr: res_d = ctl_f.div_zero ? mdsu_pkg::Uint32Max : quo_shr[DW-1:0];
      default:                 res_d = ctl_f.bypass;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_f.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

>>> rtl/mdsu_checker.sv
// Port-level checker for the multiply, divide and shift unit, with its bind.
module mdsu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [mdsu_pkg::KindW-1:0]  kind_i,
  input logic [mdsu_pkg::DataW-1:0]  multiplicand_i,
  input logic [mdsu_pkg::DataW-1:0]  multiplier_i,
  input logic [mdsu_pkg::DataW-1:0]  divisor_i,
  input logic [mdsu_pkg::ShiftW-1:0] shift_i,
  input logic                        valid_o,
  input logic [mdsu_pkg::DataW-1:0]  result_o
);

  logic [mdsu_pkg::DataW-1:0] low_prod;
  assign low_prod = multiplicand_i * multiplier_i;

  // The unit never holds off a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy_o raised");

  // Every result strobe follows an accepted beat by the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, mdsu_pkg::Latency))
    else $error("result strobe without a matching beat");

  // A zero divisor in the dividing kinds yields all ones.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(divisor_i == '0 && (kind_i == mdsu_pkg::KindMulDiv ||
      kind_i == mdsu_pkg::KindMulDivShr || kind_i == mdsu_pkg::KindMulShlDiv),
      mdsu_pkg::Latency) |-> result_o == mdsu_pkg::Uint32Max)
    else $error("zero divisor result wrong");

  // Undefined kinds give zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(kind_i > mdsu_pkg::KindUmulShr, mdsu_pkg::Latency) |-> result_o == '0)
    else $error("undefined kind not zero");

  // An unsigned multiply with no shift returns the low product bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(kind_i == mdsu_pkg::KindUmulShr && shift_i == '0, mdsu_pkg::Latency)
    |-> result_o == $past(low_prod, mdsu_pkg::Latency))
    else $error("plain product wrong");

endmodule

bind multiply_divide_shift_unit mdsu_checker u_mdsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .kind_i         (kind_i),
  .multiplicand_i (multiplicand_i),
  .multiplier_i   (multiplier_i),
  .divisor_i      (divisor_i),
  .shift_i        (shift_i),
  .valid_o        (valid_o),
  .result_o       (result_o)
);

>>> dv/tb_top.sv
// Self-checking testbench for the multiply, divide and shift unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned NumRandom = 1400;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic [mdsu_pkg::KindW-1:0]  kind_i;
  logic [mdsu_pkg::DataW-1:0]  multiplicand_i;
  logic [mdsu_pkg::DataW-1:0]  multiplier_i;
  logic [mdsu_pkg::DataW-1:0]  divisor_i;
  logic [mdsu_pkg::ShiftW-1:0] shift_i;
  logic                        valid_o;
  logic [mdsu_pkg::DataW-1:0]  result_o;

  logic [mdsu_pkg::DataW-1:0] expected_results[$];
  int unsigned                n_mismatch;
  int unsigned                n_checked;
  int unsigned                n_beats;
  int unsigned                kind_seen[8];

  multiply_divide_shift_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .multiplicand_i (multiplicand_i),
    .multiplier_i   (multiplier_i),
    .divisor_i      (divisor_i),
    .shift_i        (shift_i),
    .valid_o        (valid_o),
    .result_o       (result_o)
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Computes the result of one operation.
  function automatic logic [mdsu_pkg::DataW-1:0] mds_result(
      logic [mdsu_pkg::KindW-1:0] kind,
      logic [mdsu_pkg::DataW-1:0] mcand, logic [mdsu_pkg::DataW-1:0] mplier,
      logic [mdsu_pkg::DataW-1:0] den, logic [mdsu_pkg::ShiftW-1:0] sh);
    logic [mdsu_pkg::ProdW-1:0] prod;
    logic [mdsu_pkg::ProdW-1:0] ext;
    logic [mdsu_pkg::ProdW-1:0] value;
    prod  = {32'd0, mcand} * {32'd0, mplier};
    value = '0;
    case (kind)
      mdsu_pkg::KindMulDiv: begin
        value = (den == 0) ? {32'd0, mdsu_pkg::Uint32Max} : prod / {32'd0, den};
      end
      mdsu_pkg::KindMulDivShr: begin
        value = (den == 0) ? {32'd0, mdsu_pkg::Uint32Max} : (prod / {32'd0, den}) >> sh;
      end
      mdsu_pkg::KindMulShlDiv: begin
        value = (den == 0) ? {32'd0, mdsu_pkg::Uint32Max} : (prod << sh) / {32'd0, den};
      end
      mdsu_pkg::KindSmulShr: begin
        ext   = {{32{mcand[31]}}, mcand};
        value = (ext * {32'd0, mplier}) >> sh;
      end
      mdsu_pkg::KindUmulShr: begin
        value = prod >> sh;
      end
      default: begin
        value = '0;
      end
    endcase
    return value[mdsu_pkg::DataW-1:0];
  endfunction

  // Sends one beat, after a random gap unless gaps is cleared, and records its expected result.
  task automatic send_beat(logic [mdsu_pkg::KindW-1:0] kind,
      logic [mdsu_pkg::DataW-1:0] mcand, logic [mdsu_pkg::DataW-1:0] mplier,
      logic [mdsu_pkg::DataW-1:0] den, logic [mdsu_pkg::ShiftW-1:0] sh,
      bit gaps = 1'b1);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    kind_i         <= kind;
    multiplicand_i <= mcand;
    multiplier_i   <= mplier;
    divisor_i      <= den;
    shift_i        <= sh;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_results.push_back(mds_result(kind, mcand, mplier, den, sh));
    kind_seen[kind]++;
    n_beats++;
  endtask

  // Drops start once the last beat has gone.
  task automatic stop_sending();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Checks each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("Unexpected result beat %h", result_o);
      end else begin
        logic [mdsu_pkg::DataW-1:0] want;
        want = expected_results.pop_front();
        n_checked++;
        if (result_o !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("Result mismatch: expected %h, got %h", want, result_o);
          end
        end
      end
    end
  end

  // Extreme operands for every operation, with zero and unit divisors.
  task automatic test_extremes();
    for (int k = 0; k <= 4; k++) begin
      send_beat(3'(k), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 6'd0);
      send_beat(3'(k), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
      send_beat(3'(k), 32'h8000_0000, 32'h0000_0003, 32'd0, 6'd1);
      send_beat(3'(k), 32'd0, 32'd0, 32'd0, 6'd32);
    end
  endtask

  // Unused operand values and out-of-range kinds.
  task automatic test_special_cases();
    send_beat(mdsu_pkg::KindMulDiv, 32'd1000, 32'd7, 32'd3, 6'h3F);
    send_beat(mdsu_pkg::KindSmulShr, 32'hFFFF_FFFE, 32'd5, 32'd0, 6'd0);
    send_beat(mdsu_pkg::KindUmulShr, 32'h1234_5678, 32'd9, 32'd0, 6'd4);
    send_beat(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 6'd1);
    send_beat(3'd6, 32'd1, 32'd1, 32'd1, 6'd0);
    send_beat(3'd7, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd0, 6'h2A);
  endtask

  // Random operations; some run back to back to fill the pipeline.
  task automatic test_random();
    logic [mdsu_pkg::KindW-1:0]  kind;
    logic [mdsu_pkg::DataW-1:0]  den;
    logic [mdsu_pkg::ShiftW-1:0] sh;
    bit                          burst;
    for (int i = 0; i < NumRandom; i++) begin
      if ((i % 100) == 0) burst = ($urandom_range(0, 2) == 0);
      kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 5))
        0:       den = 32'd0;
        1:       den = $urandom_range(1, 16);
        2:       den = 32'hFFFF_FFFF;
        default: den = $urandom;
      endcase
      sh = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 3))
                                       : 6'($urandom_range(0, 63));
      send_beat(kind, $urandom, $urandom, den, sh, !burst);
    end
  endtask

  initial begin
    int unsigned drain;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    kind_i         = '0;
    multiplicand_i = '0;
    multiplier_i   = '0;
    divisor_i      = '0;
    shift_i        = '0;
    n_mismatch     = 0;
    n_checked      = 0;
    n_beats        = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_special_cases();
    test_random();
    stop_sending();

    // Wait for the pipeline to drain, then a little longer.
    drain = 0;
    while (expected_results.size() != 0 && drain < 10 * mdsu_pkg::Latency) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (mdsu_pkg::Latency + 10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      n_mismatch++;
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display("Sent %0d beats over kinds 0-7 (%0d/%0d/%0d/%0d/%0d/%0d), checked %0d results.",
             n_beats, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4], kind_seen[5] + kind_seen[6] + kind_seen[7], n_checked);
    $display("Mismatches: %0d.", n_mismatch);
    if (n_mismatch == 0) begin
      $display("** multiply_divide_shift_unit: PASSED **");
    end else begin
      $display("** multiply_divide_shift_unit: FAILED **");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #2ms;
    $display("Timeout.");
    $display("** multiply_divide_shift_unit: FAILED **");
    $finish;
  end

endmodule
